// ===== design/quoted_word_splitter_macros.svh =====
// Assertion macros used by the splitter state module.
`ifndef QUOTED_WORD_SPLITTER_MACROS_SVH
`define QUOTED_WORD_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qws check failed");

// Next-cycle implication, disabled while reset is held.
`define QWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qws check failed");

`endif

// ===== design/qws_pkg.sv =====
package qws_pkg;

    localparam int QWS_COUNT_BITS = 16;
    localparam int WORD_COUNT_W   = 16;

    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_SQUOTE    = 8'h27;
    localparam logic [7:0]  CH_DQUOTE    = 8'h22;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [31:0] WS_MASK_LO   = 32'h0000_3e00;
    localparam logic [31:0] WS_MASK_HI   = 32'h0000_0001;

    typedef struct packed {
        logic white;
        logic bslash;
        logic squote;
        logic dquote;
        logic space;
    } t_byte_class;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    word_start;
        logic [WORD_COUNT_W-1:0] word_count;
        logic                    end_of_text;
    } t_result;

endpackage

// ===== design/qws_if.sv =====
interface qws_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface qws_word_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        word_start;
    logic [15:0] word_count;
    logic        end_of_text;

    modport source (output valid, output out_byte, output word_start,
                    output word_count, output end_of_text, input ready);
    modport sink   (input valid, input out_byte, input word_start,
                    input word_count, input end_of_text, output ready);
endinterface

// ===== design/quoted_word_splitter.sv =====
// Quoted word splitter: splits a byte stream into shell-style words.
// Input channel i_in carries one text byte per transfer plus is_last, which
// marks the final byte of a text. Output channel o_out carries one result
// per input byte: the byte (a splitting space becomes zero), a word-start
// flag, the running word count and an end-of-text flag.
// Result valid comes in the cycle after the input transfer, through a single
// output register. Throughput: one byte per cycle while o_out.ready stays
// high; all per-byte work is a classify compare plus a few flag updates and
// one count increment, done in the cycle the byte is taken.
// Stall: when the receiver holds ready low with a result pending, i_in.ready
// drops and the result holds; input is taken again in the cycle the pending
// result transfers.
// Reset (synchronous, active low): output empty, tokenizer state back to the
// start of a text. After a byte with is_last, state returns to the same start
// condition, so the next byte begins a new text.
// COUNT_BITS sets the saturation point of the count: 2^COUNT_BITS-1, capped
// at the 16-bit field limit.
module quoted_word_splitter
    import qws_pkg::*;
#(
    parameter int COUNT_BITS = QWS_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qws_byte_if.sink          i_in,
    qws_word_if.source        o_out
);

    t_byte_class byte_class;
    t_result     result;
    logic        in_accept;

    logic        r_valid;
    t_result     r_result;

    assign i_in.ready = !r_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    qws_class u_class (
        .i_byte  (i_in.text_byte),
        .o_class (byte_class)
    );

    qws_state #(
        .COUNT_BITS (COUNT_BITS)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.text_byte),
        .i_last   (i_in.is_last),
        .i_class  (byte_class),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_result.out_byte;
    assign o_out.word_start  = r_result.word_start;
    assign o_out.word_count  = r_result.word_count;
    assign o_out.end_of_text = r_result.end_of_text;

endmodule

// ===== design/qws_class.sv =====
module qws_class
    import qws_pkg::*;
(
    input  logic [7:0]  i_byte,
    output t_byte_class o_class
);

    logic ws_lo;
    logic ws_hi;

    // whitespace lookup only covers codes below 64
    assign ws_lo = WS_MASK_LO[i_byte[4:0]];
    assign ws_hi = WS_MASK_HI[i_byte[4:0]];

    always_comb begin
        o_class.white  = (i_byte[7:6] == 2'b00) && (i_byte[5] ? ws_hi : ws_lo);
        o_class.bslash = (i_byte == CH_BACKSLASH);
        o_class.squote = (i_byte == CH_SQUOTE);
        o_class.dquote = (i_byte == CH_DQUOTE);
        o_class.space  = (i_byte == CH_SPACE);
    end

endmodule

// ===== design/qws_state.sv =====
`include "quoted_word_splitter_macros.svh"

module qws_state
    import qws_pkg::*;
#(
    parameter int COUNT_BITS = QWS_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  t_byte_class i_class,
    output t_result     o_result
);

    localparam int CNT_W = (COUNT_BITS > WORD_COUNT_W) ? WORD_COUNT_W : COUNT_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic             r_lead;
    logic             r_esc;
    logic             r_qopen;
    logic             r_qdbl;
    logic             r_split;
    logic [CNT_W-1:0] r_words;

    logic             n_lead;
    logic             n_esc;
    logic             n_qopen;
    logic             n_qdbl;
    logic             n_split;
    logic [CNT_W-1:0] n_words;

    logic             start;
    logic [7:0]       ob;

    always_comb begin
        n_lead  = r_lead;
        n_esc   = r_esc;
        n_qopen = r_qopen;
        n_qdbl  = r_qdbl;
        n_split = r_split;
        n_words = r_words;
        start   = 1'b0;
        ob      = i_byte;

        if (!(r_lead && i_class.white)) begin
            start   = r_lead || (r_split && !i_class.white);
            n_lead  = 1'b0;
            n_split = 1'b0;
            if (start && (r_words != CNT_MAX)) begin
                n_words = r_words + 1'b1;
            end

            unique if (i_class.bslash) begin
                n_esc = !r_esc;
            end else if (i_class.squote || i_class.dquote) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (!r_qopen) begin
                    n_qopen = 1'b1;
                    n_qdbl  = i_class.dquote;
                end else if (r_qdbl == i_class.dquote) begin
                    n_qopen = 1'b0;
                end
            end else if (i_class.space) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (!r_qopen) begin
                    ob      = 8'h00;
                    n_split = 1'b1;
                end
            end else begin
                n_esc = 1'b0;
            end
        end

        o_result.out_byte    = ob;
        o_result.word_start  = start;
        o_result.word_count  = WORD_COUNT_W'(n_words);
        o_result.end_of_text = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= 1'b1;
            r_esc   <= 1'b0;
            r_qopen <= 1'b0;
            r_qdbl  <= 1'b0;
            r_split <= 1'b0;
            r_words <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                // text ends: back to the reset state for the next text
                r_lead  <= 1'b1;
                r_esc   <= 1'b0;
                r_qopen <= 1'b0;
                r_qdbl  <= 1'b0;
                r_split <= 1'b0;
                r_words <= '0;
            end else begin
                r_lead  <= n_lead;
                r_esc   <= n_esc;
                r_qopen <= n_qopen;
                r_qdbl  <= n_qdbl;
                r_split <= n_split;
                r_words <= n_words;
            end
        end
    end

    `QWS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last, r_lead && (r_words == '0))
    `QWS_ASSERT_NOW(a_lead_idle, i_clk, i_rst_n, r_lead, !r_esc && !r_qopen && !r_split && (r_words == '0))
    `QWS_ASSERT_NOW(a_start_counted, i_clk, i_rst_n, start, o_result.word_count != '0)
    `QWS_ASSERT_NOW(a_split_zero, i_clk, i_rst_n, n_split && !r_lead, ob == 8'h00)

endmodule
